// File: src/fvn_pkg.sv
// Package with the shared timing constants and control types of the fractal value noise block.
package fvn_pkg;

  // Width of the phase counter within one slot of the cell chain.
  localparam int unsigned PhaseW     = 5;

  // Phases within a slot.
  localparam logic [PhaseW-1:0] PhHashFirst = 5'd3;
  localparam logic [PhaseW-1:0] PhHashLast  = 5'd18;
  localparam logic [PhaseW-1:0] PhSmooth    = 5'd19;
  localparam logic [PhaseW-1:0] PhLerpX     = 5'd20;
  localparam logic [PhaseW-1:0] PhLerpY     = 5'd21;
  localparam logic [PhaseW-1:0] PhAccum     = 5'd22;
  localparam logic [PhaseW-1:0] PhLast      = 5'd23;

  // Configuration register indexes.
  localparam logic RegOctaveCount = 1'b0;
  localparam logic RegPersistence = 1'b1;

  // Amplitude of the first octave, 1.0 in Q.16.
  localparam logic [16:0] AmpOne = 17'h10000;

  // Chain timing shared by all cells.
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              advance;
  } ctl_t;

endpackage

// File: src/fvn_hash.sv
// Pipelined 32-bit integer lattice hash that returns a Q.16 lattice value.
module fvn_hash (
  input  logic               clk_i,
  input  logic [31:0]        lx_i,
  input  logic [31:0]        ly_i,
  output logic signed [17:0] val_o
);

  logic [31:0] n0;
  logic [31:0] n1_q, n2_q, n3_q, sq_q, qv_q;
  logic [31:0] h;

  assign n0 = lx_i + ly_i * 32'd57;

  always_ff @(posedge clk_i) begin
    n1_q <= (n0 << 13) ^ n0;
    n2_q <= n1_q;
    sq_q <= n1_q * n1_q;
    n3_q <= n2_q;
    qv_q <= sq_q * 32'd15731 + 32'd789221;
  end

  assign h     = n3_q * qv_q + 32'd1376312589;
  assign val_o = $signed(18'h10000) - $signed({1'b0, h[30:14]});

endmodule

// File: src/fvn_cell.sv
// One octave cell of the chain: hashes a 4x4 lattice patch, smooths, interpolates and accumulates.
module fvn_cell #(
  parameter int unsigned OCT       = 0,
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned SUM_W     = 22
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fvn_pkg::ctl_t           ctl_i,
  input  logic [3:0]              octave_count_i,
  input  logic [15:0]             persistence_i,
  input  logic                    in_valid_i,
  input  logic [23:0]             in_x_i,
  input  logic [23:0]             in_y_i,
  input  logic signed [SUM_W-1:0] in_sum_i,
  input  logic [16:0]             in_amp_i,
  output logic                    out_valid_o,
  output logic [23:0]             out_x_o,
  output logic [23:0]             out_y_o,
  output logic signed [SUM_W-1:0] out_sum_o,
  output logic [16:0]             out_amp_o
);

  localparam int unsigned SX_W = 24 + OCT;
  localparam logic [SX_W-1:0] FMASK = SX_W'((1 << FRAC_BITS) - 1);

  logic                    valid_q;
  logic [23:0]             x_q, y_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [16:0]             amp_q;

  logic [SX_W-1:0] sx, sy;
  logic [31:0]     ix, iy, lx, ly;
  logic [15:0]     tx, ty;
  logic signed [17:0] hval;
  logic signed [17:0] lat_q [16];
  logic signed [17:0] sm_d [4];
  logic signed [17:0] sm_q [4];
  logic signed [17:0] lx0_q, lx1_q, vy_q;
  logic signed [17:0] lx0_d, lx1_d, vy_d;
  logic signed [35:0] prod;
  logic signed [19:0] contrib;
  logic [32:0]        amp_prod;
  logic               active;

  function automatic logic signed [21:0] ext22(input logic signed [17:0] v);
    ext22 = {{4{v[17]}}, v};
  endfunction

  function automatic logic signed [17:0] lerp(input logic signed [17:0] a,
                                              input logic signed [17:0] b,
                                              input logic [15:0] t);
    logic signed [18:0] d;
    logic signed [35:0] p;
    logic signed [19:0] r;
    d = {b[17], b} - {a[17], a};
    p = d * $signed({1'b0, t});
    r = {{2{a[17]}}, a} + $signed(p[35:16]);
    lerp = r[17:0];
  endfunction

  // Scaled coordinates of this octave.
  assign sx = SX_W'(x_q) << OCT;
  assign sy = SX_W'(y_q) << OCT;
  assign ix = 32'(sx >> FRAC_BITS);
  assign iy = 32'(sy >> FRAC_BITS);
  assign tx = 16'((sx & FMASK) << (16 - FRAC_BITS));
  assign ty = 16'((sy & FMASK) << (16 - FRAC_BITS));

  // Lattice point of patch entry 4*row + col is (ix - 1 + col, iy - 1 + row).
  assign lx = ix + 32'(ctl_i.phase[1:0]) - 32'd1;
  assign ly = iy + 32'(ctl_i.phase[3:2]) - 32'd1;

  fvn_hash u_hash (
    .clk_i (clk_i),
    .lx_i  (lx),
    .ly_i  (ly),
    .val_o (hval)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.phase >= fvn_pkg::PhHashFirst && ctl_i.phase <= fvn_pkg::PhHashLast) begin
      lat_q[4'(ctl_i.phase - fvn_pkg::PhHashFirst)] <= hval;
    end
  end

  // 3x3 smoothing of the four inner lattice points.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      int c;
      int r;
      logic signed [21:0] acc;
      c = 1 + (k % 2);
      r = 1 + (k / 2);
      acc = (ext22(lat_q[r*4+c]) <<< 2)
          + ((ext22(lat_q[(r-1)*4+c]) + ext22(lat_q[(r+1)*4+c])
            + ext22(lat_q[r*4+c-1]) + ext22(lat_q[r*4+c+1])) <<< 1)
          + ext22(lat_q[(r-1)*4+c-1]) + ext22(lat_q[(r-1)*4+c+1])
          + ext22(lat_q[(r+1)*4+c-1]) + ext22(lat_q[(r+1)*4+c+1]);
      sm_d[k] = acc[21:4];
    end
  end

  assign lx0_d    = lerp(sm_q[0], sm_q[1], tx);
  assign lx1_d    = lerp(sm_q[2], sm_q[3], tx);
  assign vy_d     = lerp(lx0_q, lx1_q, ty);
  assign prod     = $signed({1'b0, amp_q}) * vy_q;
  assign contrib  = $signed(prod[35:16]);
  assign active   = valid_q && (4'(OCT) < octave_count_i);
  assign amp_prod = amp_q * persistence_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.phase == fvn_pkg::PhSmooth) begin
      for (int k = 0; k < 4; k++) begin
        sm_q[k] <= sm_d[k];
      end
    end
    if (ctl_i.phase == fvn_pkg::PhLerpX) begin
      lx0_q <= lx0_d;
      lx1_q <= lx1_d;
    end
    if (ctl_i.phase == fvn_pkg::PhLerpY) begin
      vy_q <= vy_d;
    end
    if (ctl_i.advance) begin
      x_q   <= in_x_i;
      y_q   <= in_y_i;
      sum_q <= in_sum_i;
      amp_q <= in_amp_i;
    end else if (ctl_i.phase == fvn_pkg::PhAccum && active) begin
      sum_q <= sum_q + SUM_W'(contrib);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.advance) begin
      valid_q <= in_valid_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_sum_o   = sum_q;
  assign out_amp_o   = amp_prod[32:16];

endmodule

// File: src/fractal_value_noise_top.sv
// Top level of the fractal value noise block: config registers, slot timing, cell chain, output.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | to block  | in_valid_i / in_stall_o    | x_coord_i, y_coord_i
//  out     | from block| out_valid_o / out_stall_i  | noise_value_o
//  cfg     | to block  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// The chain moves in slots: one cell per octave hashes its 16 lattice points
// through a three-stage hash pipeline, then smooths, interpolates and adds its contribution.
// An item is taken only as the chain advances at the end of a slot, and passes through every cell.
// Reset clears the slot counter, the valid bits and the output valid flag and loads the
// register defaults. A stalled output holds the whole chain at the end of its slot.
module fractal_value_noise_top #(
  parameter int unsigned MAX_OCTAVES         = 8,
  parameter int unsigned COORD_FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        x_coord_i,
  input  logic [23:0]        y_coord_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [18:0] noise_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // Each octave adds at most one unit, so the sum needs log2 of the octave count more bits.
  localparam int unsigned SUM_W = 19 + $clog2(MAX_OCTAVES);

  logic [3:0]  octave_count_q;
  logic [15:0] persistence_q;
  logic [fvn_pkg::PhaseW-1:0] phase_q;
  fvn_pkg::ctl_t ctl;
  logic out_valid_q;
  logic signed [18:0] noise_q;

  logic                    cv   [MAX_OCTAVES+1];
  logic [23:0]             cx   [MAX_OCTAVES+1];
  logic [23:0]             cy   [MAX_OCTAVES+1];
  logic signed [SUM_W-1:0] csum [MAX_OCTAVES+1];
  logic [16:0]             camp [MAX_OCTAVES+1];
  logic signed [SUM_W-1:0] last_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= 4'd8;
      persistence_q  <= 16'd16384;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fvn_pkg::RegOctaveCount: octave_count_q <= cfg_data_i[3:0];
        fvn_pkg::RegPersistence: persistence_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The chain advances at the end of a slot once the output register can take a result.
  assign ctl.phase   = phase_q;
  assign ctl.advance = (phase_q == fvn_pkg::PhLast) && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = !ctl.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (phase_q != fvn_pkg::PhLast) begin
      phase_q <= phase_q + 1'b1;
    end else if (ctl.advance) begin
      phase_q <= '0;
    end
  end

  assign cv[0]   = in_valid_i;
  assign cx[0]   = x_coord_i;
  assign cy[0]   = y_coord_i;
  assign csum[0] = '0;
  assign camp[0] = fvn_pkg::AmpOne;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    fvn_cell #(
      .OCT       (g),
      .FRAC_BITS (COORD_FRACTION_BITS),
      .SUM_W     (SUM_W)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (ctl),
      .octave_count_i (octave_count_q),
      .persistence_i  (persistence_q),
      .in_valid_i     (cv[g]),
      .in_x_i         (cx[g]),
      .in_y_i         (cy[g]),
      .in_sum_i       (csum[g]),
      .in_amp_i       (camp[g]),
      .out_valid_o    (cv[g+1]),
      .out_x_o        (cx[g+1]),
      .out_y_o        (cy[g+1]),
      .out_sum_o      (csum[g+1]),
      .out_amp_o      (camp[g+1])
    );
  end

  assign last_sum = csum[MAX_OCTAVES];

  // The sum is saturated to plus or minus two as it leaves the chain.
  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      if (last_sum > SUM_W'(131072)) begin
        noise_q <= 19'sd131072;
      end else if (last_sum < -$signed(SUM_W'(131072))) begin
        noise_q <= -19'sd131072;
      end else begin
        noise_q <= last_sum[18:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.advance) begin
      out_valid_q <= cv[MAX_OCTAVES];
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule

// File: sim/fvn_checker.sv
// Checker that predicts fractal value noise results and compares them with the block output.
`timescale 1ns / 1ps

module fvn_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [23:0]        x_coord_i,
  input  logic [23:0]        y_coord_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [18:0] noise_value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned MaxOct   = 8;
  localparam int unsigned FracBits = 8;

  logic [3:0]          octave_count_q;
  logic [15:0]         persistence_q;
  logic signed [18:0]  expected_noise_q[$];

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint lattice(bit [31:0] ix, bit [31:0] iy);
    bit [31:0] n;
    bit [31:0] h;
    n = ix + iy * 32'd57;
    n = (n << 13) ^ n;
    h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return 65536 - longint'(h >> 14);
  endfunction

  function automatic longint smoothed(bit [31:0] ix, bit [31:0] iy);
    longint corners;
    longint sides;
    corners = lattice(ix - 1, iy - 1) + lattice(ix + 1, iy - 1) +
              lattice(ix - 1, iy + 1) + lattice(ix + 1, iy + 1);
    sides = lattice(ix, iy - 1) + lattice(ix, iy + 1) +
            lattice(ix - 1, iy) + lattice(ix + 1, iy);
    return floor_div(corners + 2 * sides + 4 * lattice(ix, iy), 4);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return floor_div(a * (65536 - t) + b * t, 16);
  endfunction

  function automatic longint octave_noise(bit [23:0] x, bit [23:0] y, int i);
    bit [63:0] sx;
    bit [63:0] sy;
    bit [31:0] ix;
    bit [31:0] iy;
    longint    tx;
    longint    ty;
    sx = 64'(x) << i;
    sy = 64'(y) << i;
    ix = 32'(sx >> FracBits);
    iy = 32'(sy >> FracBits);
    tx = longint'(sx[FracBits-1:0]) << (16 - FracBits);
    ty = longint'(sy[FracBits-1:0]) << (16 - FracBits);
    return blend(blend(smoothed(ix, iy), smoothed(ix + 1, iy), tx),
                 blend(smoothed(ix, iy + 1), smoothed(ix + 1, iy + 1), tx), ty);
  endfunction

  function automatic logic signed [18:0] fbm_noise(bit [23:0] x, bit [23:0] y);
    int     count;
    longint amp;
    longint sum;
    count = (octave_count_q > MaxOct) ? MaxOct : octave_count_q;
    amp = 65536;
    sum = 0;
    for (int i = 0; i < count; i++) begin
      sum += floor_div(amp * octave_noise(x, y, i), 16);
      amp = floor_div(amp * longint'(persistence_q), 16);
    end
    if (sum > 131072) sum = 131072;
    if (sum < -131072) sum = -131072;
    return 19'(sum);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  assign pending_o = expected_noise_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [18:0] want;
    if (!rst_ni) begin
      octave_count_q <= 4'd8;
      persistence_q <= 16'd16384;
      expected_noise_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_noise_q.push_back(fbm_noise(x_coord_i, y_coord_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_noise_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", noise_value_i));
        end else begin
          want = expected_noise_q.pop_front();
          if (noise_value_i !== want) begin
            report_mismatch($sformatf("noise_value %0d, expected %0d", noise_value_i, want));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == fvn_pkg::RegOctaveCount) octave_count_q <= cfg_data_i[3:0];
        else persistence_q <= cfg_data_i;
      end
    end
  end

endmodule

// File: sim/testbench.sv
// Top of the fractal value noise testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int DrainCycles = 400;
  localparam int CycleLimit  = 3000000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [23:0]        x_coord_i;
  logic [23:0]        y_coord_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [18:0] noise_value_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [15:0]        cfg_data_i;
  int                 fail_count;
  int                 pending;
  int                 cycle_count;
  bit                 calm;

  fractal_value_noise_top DUT (.*);

  fvn_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .x_coord_i, .y_coord_i,
    .out_valid_i(out_valid_o), .out_stall_i, .noise_value_i(noise_value_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // The receiver stalls in about a fifth of the cycles unless the quiet stretch is on.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 20);
  end

  // The timeout also bounds a hung handshake anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drives one transaction and holds it until the block takes it, with a random gap first.
  // Valid stays high afterwards so that points can follow back to back.
  task automatic send_point(logic [23:0] x, logic [23:0] y);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes a register; only called when nothing is in flight.
  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // A quarter of the random points stay near zero, a quarter near the top, the rest span the whole range.
  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(2047));
      2: return 24'hFFFFFF - 24'($urandom_range(1023));
      default: return {8'($urandom_range(255)), 16'($urandom)};
    endcase
  endfunction

  initial begin
    logic [3:0]  octave_settings[6];
    logic [15:0] persistence_settings[6];
    octave_settings      = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd9};
    persistence_settings = '{16'd0, 16'd32768, 16'd16384, 16'hFFFF, 16'd1, 16'd40000};
    calm = 1'b0;
    cycle_count = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = fvn_pkg::RegOctaveCount;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points at reset settings: origin, field extremes, lattice wrap.
    send_point(24'h000000, 24'h000000);
    send_point(24'hFFFFFF, 24'hFFFFFF);
    send_point(24'hFFFFFF, 24'h000000);
    send_point(24'h000000, 24'hFFFFFF);
    send_point(24'h0000FF, 24'h000080);
    send_point(24'h800000, 24'h7FFFFF);
    send_point(24'hAAAAAA, 24'h555555);
    send_point(24'h555555, 24'hAAAAAA);
    send_point(24'h000100, 24'h000001);
    wait_idle();

    // Each phase holds one register pair, including zero and oversized octave counts.
    for (int p = 0; p < 6; p++) begin
      write_reg(fvn_pkg::RegOctaveCount, {12'h0, octave_settings[p]});
      write_reg(fvn_pkg::RegPersistence, persistence_settings[p]);
      cfg_valid_i <= 1'b0;
      send_point(24'hFFFFFF, 24'hFFFFFF);
      send_point(24'h000000, 24'h000000);
      for (int k = 0; k < 300; k++) begin
        // A stretch with no idling on either side.
        calm = (p == 2) && (k < 150);
        send_point(rand_coord(), rand_coord());
        // The sender holds off once until the block has drained.
        if (p == 1 && k == 100) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      calm = 1'b0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
